### rtl/core/b2da_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

    localparam int VALUE_W       = 31;
    localparam int CHAR_W        = 6;
    localparam int DIGITS        = 10;
    localparam int DIGIT_W       = 4;
    localparam int BCD_W         = DIGITS * DIGIT_W;
    localparam int BITS_PER_STEP = 4;
    localparam int BIN_W         = 32;
    localparam int CONV_STEPS    = BIN_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS);
    localparam int CNT_W         = $clog2(DIGITS + 1);

    localparam logic [CHAR_W-1:0] DIGIT_BASE = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] NUL_CODE   = CHAR_W'(0);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic emit_digit;
        logic emit_nul;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic digits_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### rtl/core/binary_to_decimal_ascii_top.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    value[30:0]
// output    out        out_valid / out_stall  char_code[5:0], is_last
//
// An item is accepted, then converted four bits per cycle through the
// shift-and-add-three unit, then emitted one output beat at a time.
// A value with n decimal digits gives n + 1 beats.
// Reset is asynchronous and active low; it empties the output register.
// A stalled output holds the beat; the input is stalled until the terminator.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [b2da_pkg::VALUE_W-1:0]  value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [b2da_pkg::CHAR_W-1:0]        char_code,
    output logic                               is_last
);
    import b2da_pkg::*;

    cmd_t cmd;
    sts_t sts;

    b2da_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    b2da_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .char_code (char_code),
        .is_last   (is_last)
    );

endmodule

`default_nettype wire

### rtl/core/b2da_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module b2da_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire b2da_pkg::sts_t sts,
    output b2da_pkg::cmd_t     cmd
);
    import b2da_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                if (sts.conv_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    if (!sts.digits_done)
                    begin
                        cmd.emit_digit = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_nul = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A loaded beat always starts the conversion pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_CONV)
        else $error("conversion did not start after load");

    // The terminator closes the string and frees the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_nul |=> state_reg == ST_IDLE)
        else $error("controller did not return to idle after terminator");

endmodule

`default_nettype wire

### rtl/core/b2da_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module b2da_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [b2da_pkg::VALUE_W-1:0]   value,
    input  wire b2da_pkg::cmd_t                 cmd,
    output b2da_pkg::sts_t                      sts,
    input  wire logic                           out_stall,
    output logic                                out_valid,
    output logic [b2da_pkg::CHAR_W-1:0]         char_code,
    output logic                                is_last
);
    import b2da_pkg::*;

    logic [BIN_W-1:0]   bin_reg;
    logic [BIN_W-1:0]   bin_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_next;
    logic [STEP_W-1:0]  step_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   ndig;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;
    logic               out_valid_reg;
    logic [DIGIT_W-1:0] dig [DIGITS];
    logic [3:0]         dig_idx;

    // Shift-and-add-three conversion, four input bits per cycle.
    always_comb
    begin
        logic [BCD_W-1:0] b;
        logic [BIN_W-1:0] v;
        b = bcd_reg;
        v = bin_reg;
        for (int s = 0; s < BITS_PER_STEP; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (b[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
                begin
                    b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
                end
            end
            b = {b[BCD_W-2:0], v[BIN_W-1]};
            v = {v[BIN_W-2:0], 1'b0};
        end
        bcd_next = b;
        bin_next = v;
    end

    // Number of significant digits of the finished conversion; zero has one.
    always_comb
    begin
        ndig = CNT_W'(1);
        for (int d = 1; d < DIGITS; d++)
        begin
            if (bcd_next[d*DIGIT_W +: DIGIT_W] != '0)
            begin
                ndig = CNT_W'(d + 1);
            end
        end
    end

    for (genvar g = 0; g < DIGITS; g++)
    begin : g_dig
        assign dig[g] = bcd_reg[g*DIGIT_W +: DIGIT_W];
    end

    assign dig_idx = 4'(cnt_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                step_reg <= '0;
                cnt_reg  <= '0;
            end
            else if (cmd.shift)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (sts.conv_done)
                begin
                    cnt_reg <= ndig;
                end
            end
            else if (cmd.emit_digit)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end

            if (cmd.emit_digit || cmd.emit_nul)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg <= {{(BIN_W-VALUE_W){1'b0}}, value};
            bcd_reg <= '0;
        end
        else if (cmd.shift)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end

        if (cmd.emit_digit)
        begin
            out_char_reg <= DIGIT_BASE + CHAR_W'(dig[dig_idx]);
            out_last_reg <= 1'b0;
        end
        else if (cmd.emit_nul)
        begin
            out_char_reg <= NUL_CODE;
            out_last_reg <= 1'b1;
        end
    end

    assign sts.conv_done   = (step_reg == STEP_W'(CONV_STEPS - 1));
    assign sts.digits_done = (cnt_reg == '0);
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign char_code = out_char_reg;
    assign is_last   = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DIGITS))
        else $error("digit count exceeds ten");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit |-> cnt_reg != '0)
        else $error("digit emitted with no digits left");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |-> out_char_reg == NUL_CODE)
        else $error("terminator beat carries a nonzero code");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import b2da_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 240;
    localparam int MAX_SHOWN    = 10;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_DIRECTED   = 21;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } ascii_beat_t;

    typedef struct {
        logic [VALUE_W-1:0] number;
        string              text;
    } text_case_t;

    // An empty text means the row is checked against the predictor.
    text_case_t text_cases [N_DIRECTED] = '{
        '{31'd0,          "0"},
        '{31'd1,          "1"},
        '{31'd9,          "9"},
        '{31'd10,         "10"},
        '{31'd99,         "99"},
        '{31'd100,        "100"},
        '{31'd42,         ""},
        '{31'd65535,      ""},
        '{31'd123456789,  ""},
        '{31'd999999999,  "999999999"},
        '{31'd1000000000, "1000000000"},
        '{31'd1000000001, "1000000001"},
        '{31'd1234567890, ""},
        '{31'd1999999999, "1999999999"},
        '{31'd2000000000, "2000000000"},
        '{31'd2147483646, "2147483646"},
        '{31'd2147483647, "2147483647"},
        '{31'h2AAA_AAAA,  ""},
        '{31'h5555_5555,  ""},
        '{31'h4000_0000,  ""},
        '{31'h0000_0100,  ""}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [VALUE_W-1:0] value;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [CHAR_W-1:0]  char_code;
    logic               is_last;

    ascii_beat_t expected_beats [$];
    ascii_beat_t next_beat;
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned values_sent;
    int unsigned cycle_count;
    bit          no_gaps;

    always #1 clk = ~clk;

    binary_to_decimal_ascii_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .is_last   (is_last)
    );

    function automatic void predict_decimal(input logic [VALUE_W-1:0] v);
        ascii_beat_t digits [$];
        int unsigned rest;
        rest = v;
        do
        begin
            digits.push_front('{code: DIGIT_BASE + CHAR_W'(rest % 10), last: 1'b0});
            rest = rest / 10;
        end
        while (rest != 0);
        foreach (digits[i])
        begin
            expected_beats.push_back(digits[i]);
        end
        expected_beats.push_back('{code: NUL_CODE, last: 1'b1});
    endfunction

    task automatic send_value(input logic [VALUE_W-1:0] v, input string text);
        @(negedge clk);
        while (!no_gaps && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (text.len() == 0)
        begin
            predict_decimal(v);
        end
        else
        begin
            for (int i = 0; i < text.len(); i++)
            begin
                expected_beats.push_back('{code: CHAR_W'(text[i]), last: 1'b0});
            end
            expected_beats.push_back('{code: NUL_CODE, last: 1'b1});
        end
        values_sent++;
    endtask

    always @(negedge clk)
    begin
        out_stall <= !no_gaps && ($urandom_range(99) < 33);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            beats_checked++;
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                begin
                    $display("unexpected beat: char_code %0d is_last %0b", char_code, is_last);
                end
            end
            else
            begin
                next_beat = expected_beats.pop_front();
                if (next_beat.code !== char_code || next_beat.last !== is_last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $display("beat %0d: expected char_code %0d is_last %0b, got %0d %0b",
                                 beats_checked, next_beat.code, next_beat.last,
                                 char_code, is_last);
                    end
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d beats still expected",
                 cycle_count, expected_beats.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int unsigned mode;
        int unsigned digit_count;
        int unsigned lo;
        int unsigned hi;
        int unsigned v;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        value    = '0;
        no_gaps  = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_value(text_cases[i].number, text_cases[i].text);
        end

        // Most values get a random digit count so that short and long strings mix evenly.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_gaps = (i >= 100 && i < 160);
            mode = $urandom_range(9);
            if (mode < 2)
            begin
                v = $urandom & 32'h7FFF_FFFF;
            end
            else
            begin
                digit_count = $urandom_range(10, 1);
                lo = 1;
                repeat (digit_count - 1) lo = lo * 10;
                hi = (digit_count == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
                if (digit_count == 1)
                begin
                    lo = 0;
                end
                v = $urandom_range(hi, lo);
            end
            send_value(VALUE_W'(v), "");
        end

        @(negedge clk);
        in_valid <= 1'b0;
        no_gaps = 1'b0;
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d values (%0d directed, %0d random), checked %0d characters.",
                 values_sent, N_DIRECTED, RANDOM_ITEMS, beats_checked);
        $display("Both sides paused at random, with one run of 60 values back to back; %0d %s",
                 mismatches, "mismatches.");
        if (mismatches == 0 && expected_beats.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
